>>> rtl/skl_pkg.sv
package skl_pkg;

  // Field widths fixed by the interface
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;
  localparam int INDEX_W = 6;

  // Default configuration
  localparam int MAX_KEYS_DEF  = 64;
  localparam int FRAC_BITS_DEF = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic key_wr;
    logic q_cap;
    logic scan_step;
    logic nd_load;
    logic div_step;
    logic vp_load;
    logic diff_load;
    logic mul_en;
    logic add_en;
    logic res_zero;
    logic res_direct;
    logic out_load;
  } skl_cmd_t;

endpackage

>>> rtl/scalar_keyframe_lerp_unit.sv
// Load request: taken while idle, no result; loads can follow every cycle while no query is in work.
// Query request: scans the keys until one lies after the query time and interpolates between the
// bracketing keys; a query before the first or at/after the last key takes that key's value, and
// an empty table gives zero. The scan covers at most the clamped key count.
// One request is in work at a time: the next is taken the cycle after the output register loads,
// and a stalled result in the output register holds the finished query. Synchronous active-high
// reset clears the controller state, output valid and key_count, not the tables.
module scalar_keyframe_lerp_unit #(
  parameter int MAX_KEYS  = skl_pkg::MAX_KEYS_DEF,
  parameter int FRAC_BITS = skl_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               mode,
  input  logic [skl_pkg::INDEX_W-1:0]        key_index,
  input  logic signed [skl_pkg::DATA_W-1:0]  key_stamp,
  input  logic signed [skl_pkg::DATA_W-1:0]  key_value,
  input  logic signed [skl_pkg::DATA_W-1:0]  query_time,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [skl_pkg::DATA_W-1:0]  value,
  input  logic                               cfg_wen,
  input  logic [skl_pkg::COUNT_W-1:0]        cfg_wdata
);
  import skl_pkg::*;

  localparam int IW = $clog2(MAX_KEYS);

  skl_cmd_t      cmd;
  logic          gt;
  logic [IW-1:0] t_addr;
  logic [IW-1:0] v_addr;

  skl_ctrl #(
    .MAX_KEYS  (MAX_KEYS),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .gt        (gt),
    .cmd       (cmd),
    .t_addr    (t_addr),
    .v_addr    (v_addr)
  );

  skl_dpath #(
    .MAX_KEYS  (MAX_KEYS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk        (clk),
    .cmd        (cmd),
    .t_addr     (t_addr),
    .v_addr     (v_addr),
    .key_index  (key_index),
    .key_stamp  (key_stamp),
    .key_value  (key_value),
    .query_time (query_time),
    .gt         (gt),
    .value      (value)
  );

endmodule

>>> rtl/skl_dpath.sv
module skl_dpath #(
  parameter int MAX_KEYS  = skl_pkg::MAX_KEYS_DEF,
  parameter int FRAC_BITS = skl_pkg::FRAC_BITS_DEF,
  localparam int IW = $clog2(MAX_KEYS)
) (
  input  logic                                clk,
  input  skl_pkg::skl_cmd_t                   cmd,
  input  logic [IW-1:0]                       t_addr,
  input  logic [IW-1:0]                       v_addr,
  input  logic [skl_pkg::INDEX_W-1:0]         key_index,
  input  logic signed [skl_pkg::DATA_W-1:0]   key_stamp,
  input  logic signed [skl_pkg::DATA_W-1:0]   key_value,
  input  logic signed [skl_pkg::DATA_W-1:0]   query_time,
  output logic                                gt,
  output logic signed [skl_pkg::DATA_W-1:0]   value
);
  import skl_pkg::*;

  localparam int PW = DATA_W + FRAC_BITS + 2;

  logic signed [DATA_W-1:0] time_mem  [MAX_KEYS];
  logic signed [DATA_W-1:0] value_mem [MAX_KEYS];

  logic signed [DATA_W-1:0] t_rd;
  logic signed [DATA_W-1:0] v_rd;
  logic signed [DATA_W-1:0] q;
  logic signed [DATA_W-1:0] prev_t;
  logic signed [DATA_W-1:0] vp;
  logic signed [DATA_W-1:0] res;
  logic signed [DATA_W:0]   diff;
  logic signed [PW-1:0]     prod;
  logic [DATA_W-1:0]        rem;
  logic [DATA_W-1:0]        den;
  logic [FRAC_BITS-1:0]     quo;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [DATA_W:0] num_ext;
  logic [DATA_W:0] den_ext;
  logic [DATA_W:0] rem_sh;
  logic [DATA_W:0] rem_sub;
  logic            rem_ge;

  // Drop loads aimed past the table
  assign wr_en   = cmd.key_wr && (32'(key_index) < MAX_KEYS);
  assign wr_addr = IW'(key_index);

  // Key tables, one read port each
  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr]  <= key_stamp;
      value_mem[wr_addr] <= key_value;
    end
    t_rd <= time_mem[t_addr];
    v_rd <= value_mem[v_addr];
  end

  // Scan compare against the held query time
  assign gt = t_rd > q;

  // Span and offset of the bracketing keys
  assign num_ext = {q[DATA_W-1], q} - {prev_t[DATA_W-1], prev_t};
  assign den_ext = {t_rd[DATA_W-1], t_rd} - {prev_t[DATA_W-1], prev_t};

  // One restoring divide step per cycle while div_step is set
  assign rem_sh  = {rem, 1'b0};
  assign rem_sub = rem_sh - {1'b0, den};
  assign rem_ge  = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.q_cap) begin
      q <= query_time;
    end
    if (cmd.scan_step) begin
      prev_t <= t_rd;
    end
    if (cmd.nd_load) begin
      rem <= num_ext[DATA_W-1:0];
      den <= den_ext[DATA_W-1:0];
      quo <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      quo <= {quo[FRAC_BITS-2:0], rem_ge};
    end
    if (cmd.vp_load) begin
      vp <= v_rd;
    end
    if (cmd.diff_load) begin
      diff <= {v_rd[DATA_W-1], v_rd} - {vp[DATA_W-1], vp};
    end
    if (cmd.mul_en) begin
      prod <= diff * $signed({1'b0, quo});
    end
    priority if (cmd.res_zero) begin
      res <= '0;
    end else if (cmd.res_direct) begin
      res <= v_rd;
    end else if (cmd.add_en) begin
      res <= vp + DATA_W'(prod >>> FRAC_BITS);
    end
    if (cmd.out_load) begin
      value <= res;
    end
  end

endmodule

>>> rtl/skl_ctrl.sv
module skl_ctrl #(
  parameter int MAX_KEYS  = skl_pkg::MAX_KEYS_DEF,
  parameter int FRAC_BITS = skl_pkg::FRAC_BITS_DEF,
  localparam int IW = $clog2(MAX_KEYS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          cfg_wen,
  input  logic [skl_pkg::COUNT_W-1:0]   cfg_wdata,
  input  logic                          gt,
  output skl_pkg::skl_cmd_t             cmd,
  output logic [IW-1:0]                 t_addr,
  output logic [IW-1:0]                 v_addr
);
  import skl_pkg::*;

  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int DW = $clog2(FRAC_BITS);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SCAN = 9'b000000010,
    S_VB   = 9'b000000100,
    S_VC   = 9'b000001000,
    S_DIV  = 9'b000010000,
    S_MUL  = 9'b000100000,
    S_ADD  = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_LAST = 9'b100000000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [COUNT_W-1:0] key_count;
  logic [IW-1:0]     idx;
  logic [IW-1:0]     idx_next;
  logic              direct;
  logic              direct_next;
  logic [DW-1:0]     div_cnt;
  logic [DW-1:0]     div_cnt_next;
  logic [CW-1:0]     n;
  logic [CW-1:0]     idx_inc;
  logic              accept;
  logic              out_take;

  // Clamp the key count to the table depth
  assign n = (32'(key_count) > MAX_KEYS) ? CW'(MAX_KEYS) : CW'(key_count);
  assign idx_inc  = CW'(idx) + CW'(1);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign out_take = !out_valid || !out_stall;

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    direct_next  = direct;
    div_cnt_next = div_cnt;
    cmd          = '0;
    t_addr       = '0;
    v_addr       = '0;
    unique case (state)
      S_IDLE: begin
        // Take a request; loads finish here
        if (accept) begin
          if (!mode) begin
            cmd.key_wr = 1'b1;
          end else begin
            cmd.q_cap = 1'b1;
            idx_next  = '0;
            if (n == '0) begin
              cmd.res_zero = 1'b1;
              state_next   = S_FIN;
            end else begin
              state_next = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        // Compare one key per cycle, prefetch the next
        t_addr = IW'(idx_inc);
        if (gt) begin
          if (idx == '0) begin
            direct_next = 1'b1;
            v_addr      = '0;
          end else begin
            direct_next = 1'b0;
            v_addr      = idx - IW'(1);
            cmd.nd_load = 1'b1;
          end
          state_next = S_VB;
        end else begin
          cmd.scan_step = 1'b1;
          if (idx_inc == n) begin
            direct_next = 1'b1;
            v_addr      = idx;
            state_next  = S_VB;
          end else begin
            idx_next = IW'(idx_inc);
          end
        end
      end
      S_VB: begin
        // Take the edge value or the lower bracket value
        if (direct) begin
          cmd.res_direct = 1'b1;
          state_next     = S_FIN;
        end else begin
          cmd.vp_load = 1'b1;
          v_addr      = idx;
          state_next  = S_VC;
        end
      end
      S_VC: begin
        cmd.diff_load = 1'b1;
        div_cnt_next  = '0;
        state_next    = S_DIV;
      end
      S_DIV: begin
        // One fraction bit per cycle
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + DW'(1);
        if (div_cnt == DW'(FRAC_BITS - 1)) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add_en = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // Hold until the output register is free
        if (out_take) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_LAST: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      key_count <= '0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.out_load || (out_valid && out_stall);
      if (cfg_wen) begin
        key_count <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    direct  <= direct_next;
    div_cnt <= div_cnt_next;
  end

endmodule
